// ----- rtl/lucky_number_membership_assert.svh -----
// ---------------------------------------------------------------------------
// Lucky number membership assertion macros
// Concurrent assertion helpers shared by the RTL of the lucky number block.
// ---------------------------------------------------------------------------
`ifndef LUCKY_NUMBER_MEMBERSHIP_ASSERT_SVH
`define LUCKY_NUMBER_MEMBERSHIP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define LNM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lucky number block: assertion failed");

// Next-cycle implication, sampled on clk_i and held off during reset.
`define LNM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lucky number block: assertion failed");

`endif

// ----- rtl/lnm_pkg.sv -----
// ---------------------------------------------------------------------------
// Lucky number membership package
// Sizes, register map, sequencer states and memory port types.
// ---------------------------------------------------------------------------
package lnm_pkg;

  // Largest number the sieve can hold, and the widths that follow from it.
  localparam int unsigned MAX_LIMIT = 16384;
  localparam int unsigned ADDR_W    = $clog2(MAX_LIMIT);
  localparam int unsigned VAL_W     = $clog2(MAX_LIMIT + 1);

  // Fixed field and bus widths.
  localparam int unsigned QUERY_W = 16;
  localparam int unsigned LIMIT_W = 15;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PADDR_W = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(10000);

  // Step of the first removal pass, folded into the initial fill.
  localparam int unsigned FIRST_STEP = 2;

  // Register index, taken from the word address.
  typedef enum logic [0:0] {
    REG_TABLE_LIMIT = 1'b0
  } lnm_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_NEXT,
    ST_FIND,
    ST_SIEVE,
    ST_LOOKUP,
    ST_RESP
  } lnm_state_e;

  // Bitmap memory write port.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              wdata;
  } lnm_wr_t;

  // Bitmap memory read port.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } lnm_rd_t;

endpackage

// ----- rtl/lnm_channels_if.sv -----
// ---------------------------------------------------------------------------
// Lucky number membership channels
// Valid/ready channels for query beats and result beats.
// ---------------------------------------------------------------------------

// Query channel: one beat carries the number asked about.
interface lnm_query_if;
  logic                        valid;
  logic                        ready;
  logic [lnm_pkg::QUERY_W-1:0] query_value;

  modport source (output valid, output query_value, input ready);
  modport sink (input valid, input query_value, output ready);
endinterface

// Result channel: one beat carries the membership answer.
interface lnm_result_if;
  logic valid;
  logic ready;
  logic is_lucky;

  modport source (output valid, output is_lucky, input ready);
  modport sink (input valid, input is_lucky, output ready);
endinterface

// ----- rtl/lnm_bitmap_ram.sv -----
// ---------------------------------------------------------------------------
// Lucky number survivor bitmap
// One-bit-wide simple dual-port RAM: one write and one registered read.
// ---------------------------------------------------------------------------
module lnm_bitmap_ram (
  input  logic             clk_i,
  input  lnm_pkg::lnm_wr_t wr_i,
  input  lnm_pkg::lnm_rd_t rd_i,
  output logic             rdata_o
);

  // Entry n holds the survivor flag of the number n + 1.
  logic mem_q [lnm_pkg::MAX_LIMIT];
  logic rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.waddr] <= wr_i.wdata;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/lucky_number_membership.sv -----
// ---------------------------------------------------------------------------
// Lucky number membership
// Answers whether a query value is a lucky number up to a programmable limit,
// from a survivor bitmap that is sieved in memory before the first answer.
// ---------------------------------------------------------------------------
//
//   channel   direction  payload               notes
//   query_i   in         query_value[15:0]     valid/ready, one beat per query
//   result_o  out        is_lucky              valid/ready, one beat per query
//   APB       in/out     table_limit[14:0]     byte address 0, pready always high
//
// With the table built, the bitmap read for a query is issued on the accept
// edge and the answer is loaded into the output register once that is free.
// The first query after reset or after a limit write first rebuilds the
// table: a fill of 1..limit, then per pass a survivor search and a full
// read-modify-write sweep of the table over the one bitmap RAM.
// The result register lets a new query be taken while an answer still waits;
// an answer stalls in place until the result register is free.
// ---------------------------------------------------------------------------
`include "lucky_number_membership_assert.svh"

module lucky_number_membership (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  lnm_query_if.sink                          query_i,
  lnm_result_if.source                       result_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [lnm_pkg::PADDR_W-1:0]        paddr,
  input  logic [lnm_pkg::DATA_W-1:0]         pwdata,
  output logic [lnm_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);

  localparam int unsigned VAL_W  = lnm_pkg::VAL_W;
  localparam int unsigned ADDR_W = lnm_pkg::ADDR_W;

  // Sequencer state.
  lnm_pkg::lnm_state_e state_q, state_d;

  // Configuration and build state.
  logic [lnm_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic                        table_ready_q, table_ready_d;
  logic [VAL_W-1:0]            addr_q, addr_d;
  logic [VAL_W-1:0]            pos_q, pos_d;
  logic [VAL_W-1:0]            kept_q, kept_d;
  logic [VAL_W-1:0]            count_q, count_d;
  logic [VAL_W-1:0]            rank_q, rank_d;
  logic [VAL_W-1:0]            step_q, step_d;

  // Read pipeline stage: address whose data the RAM returns this cycle.
  logic                        p1_v_q, p1_v_d;
  logic [VAL_W-1:0]            p1_a_q, p1_a_d;

  // Query and result registers.
  logic [lnm_pkg::QUERY_W-1:0] query_q, query_d;
  logic                        in_range_q, in_range_d;
  logic                        res_valid_q, res_valid_d;
  logic                        res_q, res_d;

  // Memory ports and helpers.
  lnm_pkg::lnm_wr_t            wr;
  lnm_pkg::lnm_rd_t            rd;
  logic                        rd_data;
  logic [VAL_W-1:0]            lim;
  logic                        issue;
  logic [VAL_W-1:0]            addr_inc;
  logic [VAL_W-1:0]            pos_inc;
  logic [VAL_W-1:0]            rank_inc;
  logic [VAL_W-1:0]            p1_value;
  logic                        q_in_range;
  logic [ADDR_W-1:0]           q_addr;
  logic [ADDR_W-1:0]           q_addr_held;
  logic                        cfg_write;
  lnm_pkg::lnm_reg_e           reg_sel;

  // Active limit saturates at the bitmap size.
  assign lim = (32'(limit_q) > lnm_pkg::MAX_LIMIT) ? VAL_W'(lnm_pkg::MAX_LIMIT)
                                                   : VAL_W'(limit_q);

  // Sweep helpers.
  assign issue    = addr_q < lim;
  assign addr_inc = addr_q + 1'b1;
  assign pos_inc  = pos_q + 1'b1;
  assign rank_inc = rank_q + 1'b1;
  assign p1_value = p1_a_q + 1'b1;

  // Query decode: zero and values above the limit answer 0 without a read.
  assign q_in_range  = (query_i.query_value != '0) &&
                       (32'(query_i.query_value) <= 32'(lim));
  assign q_addr      = ADDR_W'(query_i.query_value - 1'b1);
  assign q_addr_held = ADDR_W'(query_q - 1'b1);

  // Register decode.
  assign reg_sel   = lnm_pkg::lnm_reg_e'(paddr[lnm_pkg::PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  // Register read data.
  always_comb begin
    case (reg_sel)
      lnm_pkg::REG_TABLE_LIMIT: prdata = lnm_pkg::DATA_W'(limit_q);
      default:                  prdata = '0;
    endcase
  end

  // Survivor bitmap.
  lnm_bitmap_ram u_bitmap (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .rd_i    (rd),
    .rdata_o (rd_data)
  );

  // Next state and datapath control.
  always_comb begin
    state_d       = state_q;
    limit_d       = limit_q;
    table_ready_d = table_ready_q;
    addr_d        = addr_q;
    pos_d         = pos_q;
    kept_d        = kept_q;
    count_d       = count_q;
    rank_d        = rank_q;
    step_d        = step_q;
    p1_v_d        = 1'b0;
    p1_a_d        = addr_q;
    query_d       = query_q;
    in_range_d    = in_range_q;
    res_valid_d   = res_valid_q;
    res_d         = res_q;
    wr            = '0;
    rd            = '0;
    query_i.ready = 1'b0;

    // A taken result beat frees the output register.
    if (result_o.ready) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      // Take a query; read at once when the table is built.
      lnm_pkg::ST_IDLE: begin
        query_i.ready = 1'b1;
        if (query_i.valid) begin
          query_d    = query_i.query_value;
          in_range_d = q_in_range;
          if (table_ready_q) begin
            rd.re    = q_in_range;
            rd.raddr = q_addr;
            state_d  = lnm_pkg::ST_RESP;
          end else begin
            addr_d  = '0;
            state_d = lnm_pkg::ST_INIT;
          end
        end
      end

      // Fill 1..limit with the survivors of the first pass: the odd numbers.
      lnm_pkg::ST_INIT: begin
        if (issue) begin
          wr.we    = 1'b1;
          wr.waddr = addr_q[ADDR_W-1:0];
          wr.wdata = (32'(addr_inc) % lnm_pkg::FIRST_STEP) != 0;
          addr_d   = addr_inc;
        end else begin
          count_d = lim - VAL_W'(32'(lim) / lnm_pkg::FIRST_STEP);
          rank_d  = VAL_W'(1);
          step_d  = VAL_W'(lnm_pkg::FIRST_STEP);
          state_d = lnm_pkg::ST_NEXT;
        end
      end

      // Move to the next rank; stop once it passes the survivor count.
      lnm_pkg::ST_NEXT: begin
        rank_d = rank_inc;
        if (rank_inc > count_q) begin
          table_ready_d = 1'b1;
          state_d       = lnm_pkg::ST_LOOKUP;
        end else begin
          addr_d  = '0;
          pos_d   = '0;
          state_d = lnm_pkg::ST_FIND;
        end
      end

      // Walk the bitmap for the survivor of the current rank.
      lnm_pkg::ST_FIND: begin
        if (issue) begin
          rd.re    = 1'b1;
          rd.raddr = addr_q[ADDR_W-1:0];
          addr_d   = addr_inc;
        end
        p1_v_d = issue;
        if (p1_v_q && rd_data) begin
          pos_d = pos_inc;
          if (pos_inc == rank_q) begin
            step_d = p1_value;
            p1_v_d = 1'b0;
            if (p1_value > count_q) begin
              table_ready_d = 1'b1;
              state_d       = lnm_pkg::ST_LOOKUP;
            end else begin
              addr_d  = '0;
              pos_d   = '0;
              kept_d  = '0;
              state_d = lnm_pkg::ST_SIEVE;
            end
          end
        end else if (!issue && !p1_v_q) begin
          table_ready_d = 1'b1;
          state_d       = lnm_pkg::ST_LOOKUP;
        end
      end

      // Remove every step-th survivor. The write trails the read by one
      // address, so the two ports never meet on the same entry.
      lnm_pkg::ST_SIEVE: begin
        if (issue) begin
          rd.re    = 1'b1;
          rd.raddr = addr_q[ADDR_W-1:0];
          addr_d   = addr_inc;
        end
        p1_v_d = issue;
        if (p1_v_q && rd_data) begin
          if (pos_inc == step_q) begin
            wr.we    = 1'b1;
            wr.waddr = p1_a_q[ADDR_W-1:0];
            wr.wdata = 1'b0;
            pos_d    = '0;
          end else begin
            pos_d  = pos_inc;
            kept_d = kept_q + 1'b1;
          end
        end
        if (!issue && !p1_v_q) begin
          count_d = kept_q;
          state_d = lnm_pkg::ST_NEXT;
        end
      end

      // Read for the query that started the build.
      lnm_pkg::ST_LOOKUP: begin
        rd.re    = in_range_q;
        rd.raddr = q_addr_held;
        state_d  = lnm_pkg::ST_RESP;
      end

      // Load the answer once the result register is free.
      lnm_pkg::ST_RESP: begin
        if (!res_valid_q || result_o.ready) begin
          res_valid_d = 1'b1;
          res_d       = in_range_q & rd_data;
          state_d     = lnm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = lnm_pkg::ST_IDLE;
      end
    endcase

    // A limit write forces a rebuild before the next answer.
    if (cfg_write) begin
      case (reg_sel)
        lnm_pkg::REG_TABLE_LIMIT: begin
          limit_d       = pwdata[lnm_pkg::LIMIT_W-1:0];
          table_ready_d = 1'b0;
        end
        default: begin
          limit_d = limit_q;
        end
      endcase
    end
  end

  // Result channel outputs.
  assign result_o.valid    = res_valid_q;
  assign result_o.is_lucky = res_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= lnm_pkg::ST_IDLE;
      limit_q       <= lnm_pkg::LIMIT_RESET;
      table_ready_q <= 1'b0;
      addr_q        <= '0;
      pos_q         <= '0;
      kept_q        <= '0;
      count_q       <= '0;
      rank_q        <= VAL_W'(1);
      step_q        <= VAL_W'(lnm_pkg::FIRST_STEP);
      p1_v_q        <= 1'b0;
      in_range_q    <= 1'b0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      limit_q       <= limit_d;
      table_ready_q <= table_ready_d;
      addr_q        <= addr_d;
      pos_q         <= pos_d;
      kept_q        <= kept_d;
      count_q       <= count_d;
      rank_q        <= rank_d;
      step_q        <= step_d;
      p1_v_q        <= p1_v_d;
      in_range_q    <= in_range_d;
      res_valid_q   <= res_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    p1_a_q  <= p1_a_d;
    query_q <= query_d;
    res_q   <= res_d;
  end

  // The sieve write never lands on the entry being read.
  `LNM_ASSERT_IMPLY(a_no_port_clash, wr.we && rd.re, wr.waddr != rd.raddr)

  // A query arriving before the table is built starts the fill.
  `LNM_ASSERT_NEXT(a_build_on_demand,
                   query_i.valid && query_i.ready && !table_ready_q,
                   state_q == lnm_pkg::ST_INIT)

  // The held query is only looked up against a finished table.
  `LNM_ASSERT_IMPLY(a_lookup_after_build, state_q == lnm_pkg::ST_LOOKUP, table_ready_q)

endmodule

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// Lucky number membership testbench
// Drives query beats and table_limit writes into the lucky number block and
// checks every answer beat against a typed answer or a bench-built sieve. A
// short table of hand-picked cases comes first. Random phases follow, each
// with its own limit, and both channels idle and stall at random.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUERY_COUNT = 750;
  localparam int unsigned MAX_WAIT    = 6;
  localparam int unsigned DIR_ROWS    = 29;

  // One outstanding answer: the query it belongs to and the expected bit.
  typedef struct {
    logic [lnm_pkg::QUERY_W-1:0] query;
    logic                        is_lucky;
  } answer_t;

  // A row of the directed table either writes the limit or sends a query.
  typedef enum logic [0:0] {
    ROW_LIMIT,
    ROW_QUERY
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] value;
    logic        typed;
    logic        answer;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [lnm_pkg::PADDR_W-1:0] paddr;
  logic [lnm_pkg::DATA_W-1:0]  pwdata;
  logic [lnm_pkg::DATA_W-1:0]  prdata;
  logic                        pready;

  lnm_query_if  query_bus ();
  lnm_result_if result_bus ();

  lucky_number_membership u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .query_i  (query_bus),
    .result_o (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Bench copy of the sieve and of the limit register.
  bit                          survivors [0:lnm_pkg::MAX_LIMIT];
  bit                          table_built = 1'b0;
  logic [lnm_pkg::LIMIT_W-1:0] limit_reg = lnm_pkg::LIMIT_RESET;

  answer_t     pending_answers [$];
  dir_row_t    directed_rows [DIR_ROWS];
  int unsigned fail_count    = 0;
  int unsigned checked_count = 0;
  int unsigned lucky_count   = 0;
  int unsigned sent_count    = 0;
  int unsigned limit_count   = 0;
  bit          quiet_spell   = 1'b0;

  // Limit that the sieve actually covers, saturated to the table size.
  function automatic int unsigned active_span();
    return (limit_reg > lnm_pkg::MAX_LIMIT) ? lnm_pkg::MAX_LIMIT : limit_reg;
  endfunction

  // Removes every step-th survivor in 1..span and returns how many are kept.
  function automatic int unsigned strike_every(input int unsigned span,
                                               input int unsigned step);
    int unsigned pos;
    int unsigned kept;
    int unsigned i;
    pos  = 0;
    kept = 0;
    for (i = 1; i <= span; i++) begin
      if (survivors[i]) begin
        pos++;
        if (pos % step == 0) survivors[i] = 1'b0;
        else kept++;
      end
    end
    return kept;
  endfunction

  // Full sieve: drop the even numbers, then keep striking with the next
  // survivor until that survivor is larger than the number left.
  function automatic void rebuild_survivors();
    int unsigned span;
    int unsigned count;
    int unsigned rank;
    int unsigned step;
    int unsigned pos;
    int unsigned i;
    span = active_span();
    for (i = 0; i <= lnm_pkg::MAX_LIMIT; i++) survivors[i] = 1'b1;
    survivors[0] = 1'b0;
    count = strike_every(span, lnm_pkg::FIRST_STEP);
    rank  = 1;
    while (1'b1) begin
      rank++;
      if (rank > count) break;
      step = 0;
      pos  = 0;
      for (i = 1; i <= span && step == 0; i++) begin
        if (survivors[i]) begin
          pos++;
          if (pos == rank) step = i;
        end
      end
      if (step == 0 || step > count) break;
      count = strike_every(span, step);
    end
    table_built = 1'b1;
  endfunction

  // Expected answer for one query, rebuilding the sieve when it is stale.
  function automatic logic lucky_answer(input logic [lnm_pkg::QUERY_W-1:0] value);
    if (!table_built) rebuild_survivors();
    if (value == 0 || value > active_span()) return 1'b0;
    return survivors[value];
  endfunction

  // Wait drawn for each beat on either side; none during a quiet spell.
  function automatic int unsigned draw_wait();
    return quiet_spell ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // One APB transfer to the limit register, followed by an idle bus state.
  task automatic apb_cycle(input logic write, input logic [lnm_pkg::DATA_W-1:0] wdata,
                           output logic [lnm_pkg::DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= {lnm_pkg::REG_TABLE_LIMIT, 2'b00};
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic read_back_limit();
    logic [lnm_pkg::DATA_W-1:0] got;
    apb_cycle(1'b0, '0, got);
    if (got !== lnm_pkg::DATA_W'(limit_reg)) begin
      fail_count++;
      $display("%0t: table_limit read back: expected %0d, got %0d",
               $time, limit_reg, got);
    end
  endtask

  // Drains the block, then writes a new limit with junk in the unused bits.
  task automatic set_limit(input logic [lnm_pkg::LIMIT_W-1:0] value);
    logic [lnm_pkg::DATA_W-1:0] unused;
    query_bus.valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    apb_cycle(1'b1, (lnm_pkg::DATA_W'($urandom()) << lnm_pkg::LIMIT_W) |
                    lnm_pkg::DATA_W'(value), unused);
    limit_reg   = value;
    table_built = 1'b0;
    limit_count++;
    read_back_limit();
  endtask

  // Sends one query beat and records its expected answer once accepted.
  task automatic send_query(input logic [lnm_pkg::QUERY_W-1:0] value, input logic typed,
                            input logic answer);
    int unsigned gap;
    answer_t     entry;
    gap = draw_wait();
    if (gap > 0) begin
      query_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    query_bus.valid       <= 1'b1;
    query_bus.query_value <= value;
    @(posedge clk);
    while (!query_bus.ready) @(posedge clk);
    entry.query    = value;
    entry.is_lucky = lucky_answer(value);
    if (typed) entry.is_lucky = answer;
    pending_answers.insert(pending_answers.size(), entry);
    sent_count++;
    @(negedge clk);
  endtask

  // Answer side: stall at random, then compare each beat with the oldest
  // outstanding expectation.
  initial begin : answer_checker
    int unsigned wait_cycles;
    answer_t     want;
    result_bus.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      wait_cycles = draw_wait();
      if (wait_cycles > 0) begin
        result_bus.ready <= 1'b0;
        repeat (wait_cycles) @(negedge clk);
      end
      result_bus.ready <= 1'b1;
      @(posedge clk);
      while (!result_bus.valid) @(posedge clk);
      if (pending_answers.size() == 0) begin
        fail_count++;
        $display("%0t: answer beat %0b with no query outstanding",
                 $time, result_bus.is_lucky);
      end else begin
        want = pending_answers.pop_front();
        checked_count++;
        if (want.is_lucky) lucky_count++;
        if (result_bus.is_lucky !== want.is_lucky) begin
          fail_count++;
          $display("%0t: query %0d (limit %0d): expected %0b, got %0b", $time,
                   want.query, limit_reg, want.is_lucky, result_bus.is_lucky);
        end
      end
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned                 row;
    int unsigned                 n;
    int unsigned                 k;
    int unsigned                 pick;
    int unsigned                 lim;
    int unsigned                 prev_lim;
    logic [lnm_pkg::QUERY_W-1:0] q;

    // Hand-picked cases: empty sieve, the tiniest limits where the build
    // stops early, a pass whose step equals the survivor count, the edges
    // of the limit, and a limit above the table size that saturates.
    directed_rows = '{
      '{ROW_LIMIT, 16'd0,     1'b0, 1'b0},
      '{ROW_QUERY, 16'd0,     1'b1, 1'b0},
      '{ROW_QUERY, 16'd1,     1'b1, 1'b0},
      '{ROW_QUERY, 16'd65535, 1'b1, 1'b0},
      '{ROW_LIMIT, 16'd1,     1'b0, 1'b0},
      '{ROW_QUERY, 16'd1,     1'b1, 1'b1},
      '{ROW_QUERY, 16'd2,     1'b1, 1'b0},
      '{ROW_LIMIT, 16'd2,     1'b0, 1'b0},
      '{ROW_QUERY, 16'd2,     1'b1, 1'b0},
      '{ROW_QUERY, 16'd1,     1'b1, 1'b1},
      '{ROW_LIMIT, 16'd5,     1'b0, 1'b0},
      '{ROW_QUERY, 16'd5,     1'b0, 1'b0},
      '{ROW_QUERY, 16'd3,     1'b1, 1'b1},
      '{ROW_QUERY, 16'd6,     1'b1, 1'b0},
      '{ROW_LIMIT, 16'd7,     1'b0, 1'b0},
      '{ROW_QUERY, 16'd7,     1'b1, 1'b1},
      '{ROW_QUERY, 16'd5,     1'b0, 1'b0},
      '{ROW_LIMIT, 16'd1000,  1'b0, 1'b0},
      '{ROW_QUERY, 16'd0,     1'b1, 1'b0},
      '{ROW_QUERY, 16'd999,   1'b0, 1'b0},
      '{ROW_QUERY, 16'd1000,  1'b0, 1'b0},
      '{ROW_QUERY, 16'd1001,  1'b1, 1'b0},
      '{ROW_QUERY, 16'd32768, 1'b1, 1'b0},
      '{ROW_LIMIT, 16'd32767, 1'b0, 1'b0},
      '{ROW_QUERY, 16'd16384, 1'b0, 1'b0},
      '{ROW_QUERY, 16'd16385, 1'b1, 1'b0},
      '{ROW_QUERY, 16'd65535, 1'b1, 1'b0},
      '{ROW_QUERY, 16'd1,     1'b1, 1'b1},
      '{ROW_QUERY, 16'd16383, 1'b0, 1'b0}
    };

    rst_n                 <= 1'b0;
    query_bus.valid       <= 1'b0;
    query_bus.query_value <= '0;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The limit register must come out of reset at its default.
    read_back_limit();

    for (row = 0; row < DIR_ROWS; row++) begin
      if (directed_rows[row].kind == ROW_LIMIT) begin
        set_limit(directed_rows[row].value[lnm_pkg::LIMIT_W-1:0]);
      end else begin
        send_query(directed_rows[row].value, directed_rows[row].typed,
                   directed_rows[row].answer);
      end
    end

    // Random phases: mostly small limits so that rebuilds stay cheap, some
    // medium ones, a few degenerate ones, and now and then the same limit
    // written again.
    prev_lim = 1000;
    while (sent_count < QUERY_COUNT) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) lim = $urandom_range(0, 6);
      else if (pick < 5) lim = $urandom_range(300, 1200);
      else if (pick == 5) lim = prev_lim;
      else lim = $urandom_range(1, 300);
      set_limit(lim[lnm_pkg::LIMIT_W-1:0]);
      prev_lim = lim;
      n = $urandom_range(15, 50);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(0, 29) == 0) quiet_spell = !quiet_spell;
        pick = $urandom_range(0, 9);
        if (pick < 7) q = lnm_pkg::QUERY_W'($urandom_range(0, lim + 3));
        else if (pick < 9) q = lnm_pkg::QUERY_W'($urandom_range(0, 65535));
        else q = $urandom_range(0, 1) ? '1 : '0;
        send_query(q, 1'b0, 1'b0);
      end
    end
    query_bus.valid <= 1'b0;

    // Let the last answers drain, then watch a little longer for strays.
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Sent %0d queries over %0d table_limit writes; %0d answers checked, %0d lucky.",
             sent_count, limit_count, checked_count, lucky_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: a run that never finishes is reported as a mismatch.
  initial begin : watchdog
    #400_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
